### rtl/chip8_pkg.sv
// ----------------------------------------------------------------------------
// chip8_pkg
// Shared types, constants and the hex font for the CHIP-8 executor.
// ----------------------------------------------------------------------------
package chip8_pkg;

   localparam int MEM_BYTES       = 4096;
   localparam int MEM_AW          = $clog2(MEM_BYTES);
   localparam int FONT_BYTES      = 80;
   localparam int FONT_AW         = $clog2(FONT_BYTES);
   localparam int STACK_DEPTH_DEF = 16;
   localparam int NUM_REGS        = 16;
   localparam logic [15:0] PC_RESET = 16'h0200;

   localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
      8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
      8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
      8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
      8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
      8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
      8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
      8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
      8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80
   };

   typedef struct packed {
      logic        kind;
      logic [11:0] address;
      logic [7:0]  data;
      logic [15:0] forced_opcode;
      logic [15:0] key_mask;
      logic [7:0]  random_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] program_counter;
      logic [15:0] index_value;
      logic [15:0] executed_opcode;
      logic [7:0]  delay_value;
      logic [7:0]  sound_value;
      logic        waiting_key;
      logic        unsupported;
   } rsp_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_CLEAR,
      CMD_LOAD,
      CMD_WRITE,
      CMD_FETCH_HI,
      CMD_FETCH_LO,
      CMD_FETCH_END,
      CMD_REG_READ,
      CMD_EXEC,
      CMD_BCD0,
      CMD_BCD1,
      CMD_BCD2,
      CMD_ST_RD,
      CMD_ST_WR,
      CMD_LD_RD,
      CMD_LD_WR,
      CMD_FINISH
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type code;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic req_write;
      logic req_fetch;
      logic is_bcd;
      logic is_store;
      logic is_load;
      logic move_last;
   } dp_status_type;

endpackage

### rtl/chip8_ctrl.sv
// ----------------------------------------------------------------------------
// chip8_ctrl
// Sequencer: clears memory after reset, then steps each instruction through
// fetch if needed, register read, execute, multi-byte moves and result.
// ----------------------------------------------------------------------------
module chip8_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  chip8_pkg::dp_status_type status,
   output chip8_pkg::ctrl_cmd_type  cmd,
   output logic                     busy,
   output logic                     rsp_strobe
);
   import chip8_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_WRITE, S_FETCH_HI, S_FETCH_LO, S_FETCH_END,
      S_REG_READ, S_EXEC, S_BCD0, S_BCD1, S_BCD2, S_ST_RD, S_ST_WR,
      S_LD_RD, S_LD_WR, S_FINISH, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, strobe_ff;

   always_comb begin
      state_in = state_ff;
      cmd.code = CMD_NONE;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.code = CMD_CLEAR;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.code = CMD_LOAD;
               if (status.req_write)      state_in = S_WRITE;
               else if (status.req_fetch) state_in = S_FETCH_HI;
               else                       state_in = S_REG_READ;
            end
         end
         S_WRITE: begin
            cmd.code = CMD_WRITE;
            state_in = S_DONE;
         end
         S_FETCH_HI: begin
            cmd.code = CMD_FETCH_HI;
            state_in = S_FETCH_LO;
         end
         S_FETCH_LO: begin
            cmd.code = CMD_FETCH_LO;
            state_in = S_FETCH_END;
         end
         S_FETCH_END: begin
            cmd.code = CMD_FETCH_END;
            state_in = S_REG_READ;
         end
         S_REG_READ: begin
            cmd.code = CMD_REG_READ;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.code = CMD_EXEC;
            if (status.is_bcd)        state_in = S_BCD0;
            else if (status.is_store) state_in = S_ST_RD;
            else if (status.is_load)  state_in = S_LD_RD;
            else                      state_in = S_FINISH;
         end
         S_BCD0: begin
            cmd.code = CMD_BCD0;
            state_in = S_BCD1;
         end
         S_BCD1: begin
            cmd.code = CMD_BCD1;
            state_in = S_BCD2;
         end
         S_BCD2: begin
            cmd.code = CMD_BCD2;
            state_in = S_FINISH;
         end
         S_ST_RD: begin
            cmd.code = CMD_ST_RD;
            state_in = S_ST_WR;
         end
         S_ST_WR: begin
            cmd.code = CMD_ST_WR;
            state_in = status.move_last ? S_FINISH : S_ST_RD;
         end
         S_LD_RD: begin
            cmd.code = CMD_LD_RD;
            state_in = S_LD_WR;
         end
         S_LD_WR: begin
            cmd.code = CMD_LD_WR;
            state_in = status.move_last ? S_FINISH : S_LD_RD;
         end
         S_FINISH: begin
            cmd.code = CMD_FINISH;
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         busy_ff   <= 1'b1;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= (state_in != S_IDLE);
         strobe_ff <= (state_in == S_DONE);
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule

### rtl/chip8_dpath.sv
// ----------------------------------------------------------------------------
// chip8_dpath
// Datapath: byte memory, register file, return stack, PC, index and timers,
// with the instruction execute logic.
// ----------------------------------------------------------------------------
module chip8_dpath #(
   parameter int STACK_DEPTH = chip8_pkg::STACK_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  chip8_pkg::req_type       req_item,
   input  chip8_pkg::ctrl_cmd_type  cmd,
   output chip8_pkg::dp_status_type status,
   output chip8_pkg::rsp_type       rsp_item
);
   import chip8_pkg::*;

   localparam int SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);

   logic [7:0]  mem [MEM_BYTES];
   logic [7:0]  regs [NUM_REGS];
   logic [15:0] stack_ff [STACK_DEPTH];

   req_type          req_ff;
   logic [15:0]      op_ff, pc_ff, idx_ff;
   logic [7:0]       delay_ff, sound_ff;
   logic [SP_W-1:0]  sp_ff;
   logic             waiting_ff, unsup_ff;
   logic             flag_we_ff;
   logic [7:0]       flag_val_ff;
   logic [1:0]       bcd_h_ff;
   logic [6:0]       bcd_r_ff;
   logic [3:0]       k_ff;
   logic [MEM_AW-1:0] clr_ff;
   logic [7:0]       mem_rdata_ff, va_ff, vb_ff;

   logic [3:0]  op_x, op_y, op_n;
   logic [7:0]  op_nn;
   logic [11:0] op_nnn;
   assign op_x   = op_ff[11:8];
   assign op_y   = op_ff[7:4];
   assign op_n   = op_ff[3:0];
   assign op_nn  = op_ff[7:0];
   assign op_nnn = op_ff[11:0];

   logic [15:0] idx_plus_k;
   assign idx_plus_k = idx_ff + {12'd0, k_ff};

   // bcd digits from the stored remainder
   logic [14:0] tens_prod;
   logic [3:0]  bcd_tens;
   logic [3:0]  bcd_units;
   assign tens_prod = {8'd0, bcd_r_ff} * 15'd205;
   assign bcd_tens  = tens_prod[14:11];
   assign bcd_units = 4'(bcd_r_ff - 7'(bcd_tens) * 7'd10);

   // memory ports
   logic              mem_we;
   logic [MEM_AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]        mem_wdata;
   logic [15:0]       pc_plus1;
   assign pc_plus1 = pc_ff + 16'd1;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_plus_k[MEM_AW-1:0];
      mem_wdata = va_ff;
      case (cmd.code)
         CMD_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = (clr_ff < MEM_AW'(FONT_BYTES)) ? FONT_ROM[clr_ff[FONT_AW-1:0]] : 8'd0;
         end
         CMD_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = req_ff.address[MEM_AW-1:0];
            mem_wdata = req_ff.data;
         end
         CMD_BCD0: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff[MEM_AW-1:0];
            mem_wdata = {6'd0, bcd_h_ff};
         end
         CMD_BCD1: begin
            mem_we    = 1'b1;
            mem_waddr = MEM_AW'(idx_ff + 16'd1);
            mem_wdata = {4'd0, bcd_tens};
         end
         CMD_BCD2: begin
            mem_we    = 1'b1;
            mem_waddr = MEM_AW'(idx_ff + 16'd2);
            mem_wdata = {4'd0, bcd_units};
         end
         CMD_ST_WR: begin
            mem_we = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      case (cmd.code)
         CMD_FETCH_HI: mem_raddr = pc_ff[MEM_AW-1:0];
         CMD_FETCH_LO: mem_raddr = pc_plus1[MEM_AW-1:0];
         default:      mem_raddr = idx_plus_k[MEM_AW-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      mem_rdata_ff <= mem[mem_raddr];
   end

   // execute
   logic [15:0]     pc_ex, idx_ex;
   logic [7:0]      delay_ex, sound_ex;
   logic [SP_W-1:0] sp_ex, sp_inc, sp_dec;
   logic            push_ex, reg_we_ex, flag_we_ex, waiting_ex, unsup_ex;
   logic [7:0]      reg_wd_ex, flag_val_ex;
   logic [8:0]      add_sum;
   logic            key_held;
   logic [3:0]      key_low;
   logic [1:0]      hund;
   logic [7:0]      rnd_mod;

   assign sp_inc   = (sp_ff == SP_LAST) ? '0 : sp_ff + SP_W'(1);
   assign sp_dec   = (sp_ff == '0) ? SP_LAST : sp_ff - SP_W'(1);
   assign add_sum  = {1'b0, va_ff} + {1'b0, vb_ff};
   assign key_held = (va_ff[7:4] == 4'd0) && req_ff.key_mask[va_ff[3:0]];
   assign hund     = (va_ff >= 8'd200) ? 2'd2 : ((va_ff >= 8'd100) ? 2'd1 : 2'd0);
   assign rnd_mod  = (req_ff.random_byte == 8'hFF) ? 8'd0 : req_ff.random_byte;

   always_comb begin
      key_low = 4'd0;
      for (int i = NUM_REGS - 1; i >= 0; i--) begin
         if (req_ff.key_mask[i]) key_low = 4'(i);
      end
   end

   always_comb begin
      pc_ex       = pc_ff;
      idx_ex      = idx_ff;
      delay_ex    = delay_ff;
      sound_ex    = sound_ff;
      sp_ex       = sp_ff;
      push_ex     = 1'b0;
      reg_we_ex   = 1'b0;
      reg_wd_ex   = op_nn;
      flag_we_ex  = 1'b0;
      flag_val_ex = 8'd0;
      waiting_ex  = 1'b0;
      unsup_ex    = 1'b0;
      unique case (op_ff[15:12])
         4'h0: begin
            if (op_ff == 16'h00EE) begin
               sp_ex = sp_dec;
               pc_ex = stack_ff[sp_dec];
            end else begin
               unsup_ex = 1'b1;
            end
         end
         4'h1: pc_ex = {4'd0, op_nnn} - 16'd2;
         4'h2: begin
            push_ex = 1'b1;
            sp_ex   = sp_inc;
            pc_ex   = {4'd0, op_nnn} - 16'd2;
         end
         4'h3: if (va_ff == op_nn) pc_ex = pc_ff + 16'd2;
         4'h4: if (va_ff != op_nn) pc_ex = pc_ff + 16'd2;
         4'h5: begin
            if (op_n != 4'd0)       unsup_ex = 1'b1;
            else if (va_ff == vb_ff) pc_ex = pc_ff + 16'd2;
         end
         4'h6: reg_we_ex = 1'b1;
         4'h7: begin
            reg_we_ex = 1'b1;
            reg_wd_ex = va_ff + op_nn;
         end
         4'h8: begin
            reg_we_ex = 1'b1;
            case (op_n)
               4'h0: reg_wd_ex = vb_ff;
               4'h1: reg_wd_ex = va_ff | vb_ff;
               4'h2: reg_wd_ex = va_ff & vb_ff;
               4'h3: reg_wd_ex = va_ff ^ vb_ff;
               4'h4: begin
                  reg_wd_ex   = add_sum[7:0];
                  flag_we_ex  = 1'b1;
                  flag_val_ex = {7'd0, add_sum[8]};
               end
               4'h5: begin
                  reg_wd_ex   = va_ff - vb_ff;
                  flag_we_ex  = 1'b1;
                  flag_val_ex = {7'd0, vb_ff <= va_ff};
               end
               4'h6: begin
                  reg_wd_ex   = {1'b0, va_ff[7:1]};
                  flag_we_ex  = 1'b1;
                  flag_val_ex = {7'd0, va_ff[0]};
               end
               4'h7: begin
                  reg_wd_ex   = vb_ff - va_ff;
                  flag_we_ex  = 1'b1;
                  flag_val_ex = {7'd0, va_ff <= vb_ff};
               end
               4'hE: begin
                  reg_wd_ex   = {va_ff[6:0], 1'b0};
                  flag_we_ex  = 1'b1;
                  flag_val_ex = {7'd0, va_ff[7]};
               end
               default: begin
                  reg_we_ex = 1'b0;
                  unsup_ex  = 1'b1;
               end
            endcase
         end
         4'h9: begin
            if (op_n != 4'd0)       unsup_ex = 1'b1;
            else if (va_ff != vb_ff) pc_ex = pc_ff + 16'd2;
         end
         4'hA: idx_ex = {4'd0, op_nnn};
         // port b holds v0 here
         4'hB: pc_ex = {4'd0, op_nnn} + {8'd0, vb_ff} - 16'd2;
         4'hC: begin
            reg_we_ex = 1'b1;
            reg_wd_ex = rnd_mod & op_nn;
         end
         4'hD: unsup_ex = 1'b1;
         4'hE: begin
            if (op_nn == 8'h9E) begin
               if (key_held) pc_ex = pc_ff + 16'd2;
            end else if (op_nn == 8'hA1) begin
               if (!key_held) pc_ex = pc_ff + 16'd2;
            end else begin
               unsup_ex = 1'b1;
            end
         end
         4'hF: begin
            case (op_nn)
               8'h07: begin
                  reg_we_ex = 1'b1;
                  reg_wd_ex = delay_ff;
               end
               8'h0A: begin
                  if (req_ff.key_mask == 16'd0) begin
                     waiting_ex = 1'b1;
                     pc_ex      = pc_ff - 16'd2;
                  end else begin
                     reg_we_ex = 1'b1;
                     reg_wd_ex = {4'd0, key_low};
                  end
               end
               8'h15: delay_ex = va_ff;
               8'h18: sound_ex = va_ff;
               8'h1E: idx_ex = idx_ff + {8'd0, va_ff};
               8'h29: idx_ex = {10'd0, va_ff[3:0], 2'b00} + {12'd0, va_ff[3:0]};
               8'h33, 8'h55, 8'h65: ;
               default: unsup_ex = 1'b1;
            endcase
         end
         default: unsup_ex = 1'b1;
      endcase
   end

   // register file ports
   logic       reg_we;
   logic [3:0] reg_waddr, reg_raddr_a, reg_raddr_b;
   logic [7:0] reg_wdata;

   always_comb begin
      reg_we    = 1'b0;
      reg_waddr = op_x;
      reg_wdata = reg_wd_ex;
      case (cmd.code)
         CMD_CLEAR: begin
            reg_we    = (clr_ff < MEM_AW'(NUM_REGS));
            reg_waddr = clr_ff[3:0];
            reg_wdata = 8'd0;
         end
         CMD_EXEC: reg_we = reg_we_ex;
         CMD_LD_WR: begin
            reg_we    = 1'b1;
            reg_waddr = k_ff;
            reg_wdata = mem_rdata_ff;
         end
         CMD_FINISH: begin
            reg_we    = flag_we_ff;
            reg_waddr = 4'hF;
            reg_wdata = flag_val_ff;
         end
         default: ;
      endcase
   end

   assign reg_raddr_a = (cmd.code == CMD_ST_RD) ? k_ff : op_x;
   assign reg_raddr_b = (op_ff[15:12] == 4'hB) ? 4'd0 : op_y;

   always_ff @(posedge clock) begin
      if (reg_we) regs[reg_waddr] <= reg_wdata;
      va_ff <= regs[reg_raddr_a];
      vb_ff <= regs[reg_raddr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STACK_DEPTH; i++) stack_ff[i] <= 16'd0;
      end else if (cmd.code == CMD_EXEC && push_ex) begin
         stack_ff[sp_ff] <= pc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         pc_ff    <= PC_RESET;
         idx_ff   <= 16'd0;
         delay_ff <= 8'd0;
         sound_ff <= 8'd0;
         sp_ff    <= '0;
      end else begin
         case (cmd.code)
            CMD_CLEAR: clr_ff <= clr_ff + MEM_AW'(1);
            CMD_LOAD: begin
               req_ff     <= req_item;
               op_ff      <= req_item.kind ? req_item.forced_opcode : 16'd0;
               waiting_ff <= 1'b0;
               unsup_ff   <= 1'b0;
               flag_we_ff <= 1'b0;
               k_ff       <= 4'd0;
            end
            CMD_FETCH_LO:  op_ff[15:8] <= mem_rdata_ff;
            CMD_FETCH_END: op_ff[7:0]  <= mem_rdata_ff;
            CMD_EXEC: begin
               pc_ff       <= pc_ex;
               idx_ff      <= idx_ex;
               delay_ff    <= delay_ex;
               sound_ff    <= sound_ex;
               sp_ff       <= sp_ex;
               waiting_ff  <= waiting_ex;
               unsup_ff    <= unsup_ex;
               flag_we_ff  <= flag_we_ex;
               flag_val_ff <= flag_val_ex;
               bcd_h_ff    <= hund;
               bcd_r_ff    <= 7'(va_ff - 8'(hund) * 8'd100);
            end
            CMD_ST_WR, CMD_LD_WR: k_ff <= k_ff + 4'd1;
            CMD_FINISH: begin
               pc_ff <= pc_ff + 16'd2;
               if (delay_ff != 8'd0) delay_ff <= delay_ff - 8'd1;
               if (sound_ff != 8'd0) sound_ff <= sound_ff - 8'd1;
            end
            default: ;
         endcase
      end
   end

   assign status.clear_last = (clr_ff == MEM_AW'(MEM_BYTES - 1));
   assign status.req_write  = ~req_item.kind;
   assign status.req_fetch  = (req_item.forced_opcode == 16'd0);
   assign status.is_bcd     = (op_ff[15:12] == 4'hF) && (op_nn == 8'h33);
   assign status.is_store   = (op_ff[15:12] == 4'hF) && (op_nn == 8'h55);
   assign status.is_load    = (op_ff[15:12] == 4'hF) && (op_nn == 8'h65);
   assign status.move_last  = (k_ff == op_x);

   assign rsp_item.program_counter = pc_ff;
   assign rsp_item.index_value     = idx_ff;
   assign rsp_item.executed_opcode = op_ff;
   assign rsp_item.delay_value     = delay_ff;
   assign rsp_item.sound_value     = sound_ff;
   assign rsp_item.waiting_key     = waiting_ff;
   assign rsp_item.unsupported     = unsup_ff;

endmodule

### rtl/chip8_instruction_executor.sv
// ----------------------------------------------------------------------------
// chip8_instruction_executor
// CHIP-8 core: memory byte writes for program loading and single-instruction
// execution, one result per transaction.
// ----------------------------------------------------------------------------
//  channel   ports                      handshake
//  request   start, busy, req_item      taken when start high and busy low
//  result    rsp_strobe, rsp_item       one-cycle strobe, cannot be held off
//
// After reset the core sweeps the 4096-byte memory (font then zeros), one
// byte a cycle, and busy stays high until the sweep is done.
// A write transaction only writes its byte; a given opcode skips the fetch.
// FX55/FX65 move V0..VX one register at a time, a read step then a write
// step for each; FX33 adds three memory writes.
// ----------------------------------------------------------------------------
module chip8_instruction_executor #(
   parameter int STACK_DEPTH = chip8_pkg::STACK_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  chip8_pkg::req_type req_item,
   output logic               rsp_strobe,
   output chip8_pkg::rsp_type rsp_item
);
   import chip8_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   chip8_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   chip8_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule
